// ----- rtl/ctn_pkg.sv -----
`timescale 1ns / 1ps
// Shared types for the calendar time normaliser: input fields, the carried
// item queued between front and back end, and the result fields. No dependencies.
package ctn_pkg;

  typedef struct packed {
    logic [9:0] year;
    logic [7:0] month;
    logic [8:0] day_of_month;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
  } ctn_in_t;

  // After the field carries; day and year still unbounded by the month walk
  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [9:0]  day_of_month;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } ctn_item_t;

  typedef struct packed {
    logic [2:0] day_of_week;
    logic [8:0] day_of_year;
    logic [9:0] year;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } ctn_result_t;

  localparam logic [11:0] BaseYear = 12'd1900;

endpackage

// ----- rtl/calendar_time_normalizer.sv -----
`timescale 1ns / 1ps
// Calendar time normaliser top level: stream ports, front end, item queue
// and back end. Depends on ctn_pkg, ctn_front, ctn_fifo and ctn_back.
//
// One result beat per input beat, in order. The front end carries seconds,
// minutes, hours and months in two register stages and queues the item; the
// back end then walks forward one month per cycle until the day fits, and
// finishes day of year and weekday in the states S_DOY, S_DIV, S_SUM and S_Q7
// before S_DONE. The back end takes one item at a time, and its walk takes one
// step for each whole month the day overflows (none for an already valid date,
// at most 17 for the largest inputs), so the month walk sets the throughput.
// The output register lets the back end start the next item while a result
// waits to be taken.
module calendar_time_normalizer #(
  parameter int QueueDepth = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // seconds_in[7:0], minutes_in[15:8], hours_in[23:16], day_of_month_in[32:24],
  // month_in[40:33], year_in[50:41], zero pad [55:51]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // seconds_out[5:0], minutes_out[11:6], hours_out[16:12], day_of_month_out[21:17],
  // month_out[25:22], year_out[35:26], day_of_year[44:36], day_of_week[47:45]
  output logic [47:0] m_axis_tdata
);
  import ctn_pkg::*;

  ctn_in_t     in_item;
  ctn_item_t   push_item;
  ctn_item_t   pop_item;
  ctn_result_t result;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;

  assign in_item.seconds      = s_axis_tdata[7:0];
  assign in_item.minutes      = s_axis_tdata[15:8];
  assign in_item.hours        = s_axis_tdata[23:16];
  assign in_item.day_of_month = s_axis_tdata[32:24];
  assign in_item.month        = s_axis_tdata[40:33];
  assign in_item.year         = s_axis_tdata[50:41];

  assign m_axis_tdata = {result.day_of_week, result.day_of_year, result.year,
                         result.month, result.day_of_month, result.hours,
                         result.minutes, result.seconds};

  ctn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  ctn_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  ctn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .result    (result)
  );

endmodule

// ----- rtl/ctn_front.sv -----
`timescale 1ns / 1ps
// Front end: takes input beats and carries seconds, minutes, hours and months
// over two register stages. Depends on ctn_pkg.
module ctn_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ctn_pkg::ctn_in_t   in_item,
  output logic               push,
  output ctn_pkg::ctn_item_t push_item,
  input  logic               full
);
  import ctn_pkg::*;

  // quotient by 60 for values up to 299
  function automatic logic [2:0] div60(input logic [8:0] v);
    logic [2:0] q;
    if (v >= 9'd240) q = 3'd4;
    else if (v >= 9'd180) q = 3'd3;
    else if (v >= 9'd120) q = 3'd2;
    else if (v >= 9'd60) q = 3'd1;
    else q = 3'd0;
    return q;
  endfunction

  logic       s1_valid;
  ctn_in_t    s1;
  logic       s2_valid;
  logic [5:0] s2_sec;
  logic [5:0] s2_min;
  logic [8:0] s2_hr;
  logic [8:0] s2_day;
  logic [3:0] s2_mon;
  logic [10:0] s2_yr;

  logic        s2_take;
  logic [2:0]  sec_q;
  logic [8:0]  sec_rem;
  logic [8:0]  min_t;
  logic [2:0]  min_q;
  logic [8:0]  min_rem;
  logic [15:0] mon_prod;
  logic [4:0]  mon_q;
  logic [7:0]  mon_rem;
  logic [16:0] hr_prod;
  logic [4:0]  hr_q;
  logic [8:0]  hr_rem;
  logic [9:0]  day_t;

  assign push     = s2_valid && !full;
  assign s2_take  = !s2_valid || push;
  assign in_ready = !s1_valid || s2_take;

  // stage 1: seconds and minutes carry, month to year carry
  always_comb begin
    sec_q    = div60({1'b0, s1.seconds});
    sec_rem  = {1'b0, s1.seconds} - 9'(sec_q) * 9'd60;
    min_t    = {1'b0, s1.minutes} + 9'(sec_q);
    min_q    = div60(min_t);
    min_rem  = min_t - 9'(min_q) * 9'd60;
    // /12 by reciprocal 171/2048, exact for values below 256
    mon_prod = 16'(s1.month) * 16'd171;
    mon_q    = mon_prod[15:11];
    mon_rem  = s1.month - 8'(mon_q) * 8'd12;
  end

  // stage 2: hours to days carry, /24 by reciprocal 171/4096
  always_comb begin
    hr_prod = 17'(s2_hr) * 17'd171;
    hr_q    = hr_prod[16:12];
    hr_rem  = s2_hr - 9'(hr_q) * 9'd24;
    day_t   = 10'(s2_day) + 10'(hr_q);
    push_item.seconds      = s2_sec;
    push_item.minutes      = s2_min;
    push_item.hours        = hr_rem[4:0];
    push_item.day_of_month = (day_t == 10'd0) ? 10'd1 : day_t;
    push_item.month        = s2_mon;
    push_item.year         = s2_yr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s2_take) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1 <= in_item;
    if (s1_valid && s2_take) begin
      s2_sec <= sec_rem[5:0];
      s2_min <= min_rem[5:0];
      s2_hr  <= 9'(s1.hours) + 9'(min_q);
      s2_day <= s1.day_of_month;
      s2_mon <= mon_rem[3:0];
      s2_yr  <= 11'(s1.year) + 11'(mon_q);
    end
  end

endmodule

// ----- rtl/ctn_fifo.sv -----
`timescale 1ns / 1ps
// Short queue of carried items between front and back end.
// Depends on ctn_pkg for the item type.
module ctn_fifo #(
  parameter int Depth = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ctn_pkg::ctn_item_t push_item,
  output logic               full,
  input  logic               pop,
  output ctn_pkg::ctn_item_t pop_item,
  output logic               empty
);
  import ctn_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  ctn_item_t       entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntW'(Depth));
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule

// ----- rtl/ctn_back.sv -----
`timescale 1ns / 1ps
// Back end: month walk with leap rule, day of year, Sakamoto weekday and the
// output register. Depends on ctn_pkg.
module ctn_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  input  ctn_pkg::ctn_item_t   pop_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ctn_pkg::ctn_result_t result
);
  import ctn_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MOD  = 4'd1;
  localparam logic [3:0] S_REM  = 4'd2;
  localparam logic [3:0] S_WALK = 4'd3;
  localparam logic [3:0] S_DOY  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_SUM  = 4'd6;
  localparam logic [3:0] S_Q7   = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  localparam logic [8:0] CumDays [12] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
                                          9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
  localparam logic [2:0] SakTab [12] = '{3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3,
                                         3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4};

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    logic [4:0] len;
    case (m) inside
      4'd1:                   len = 5'd28 + 5'(lp);
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  logic [3:0]  state;
  logic [5:0]  sec;
  logic [5:0]  min;
  logic [4:0]  hr;
  logic [9:0]  day;
  logic [3:0]  mon;
  logic [10:0] yr;
  logic [6:0]  q25;
  logic [4:0]  rem25;
  logic [8:0]  yd;
  logic [11:0] ys;
  logic [5:0]  sakday;
  logic [5:0]  q100;
  logic [3:0]  q400;
  logic [12:0] sum;
  logic [10:0] q7;

  logic        leap;
  logic [4:0]  len;
  logic [22:0] prod25;
  logic [10:0] rem25_w;
  logic [11:0] full_yr;
  logic [21:0] prod_a;
  logic [19:0] prod_b;
  logic [26:0] prod7;
  logic [12:0] wd_w;
  logic        out_load;

  // years since 1900 share residues mod 4 and 25 with the full year;
  // full year is a multiple of 16 when yr mod 16 is 4
  assign leap     = (yr[1:0] == 2'd0) && (rem25 != 5'd0 || yr[3:0] == 4'd4);
  assign len      = month_len(mon, leap);
  assign prod25   = 23'(yr) * 23'd2622;
  assign rem25_w  = yr - 11'(q25) * 11'd25;
  assign full_yr  = 12'(yr) + BaseYear;
  assign prod_a   = 22'(ys[11:2]) * 22'd2622;
  assign prod_b   = 20'(ys[11:4]) * 20'd2622;
  assign prod7    = 27'(sum) * 27'd9363;
  assign wd_w     = sum - 13'(q7) * 13'd7;
  assign pop      = (state == S_IDLE) && !empty;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE:  if (!empty) state <= S_MOD;
        S_MOD:   state <= S_REM;
        S_REM:   state <= S_WALK;
        S_WALK:  if (day <= 10'(len)) state <= S_DOY;
        S_DOY:   state <= S_DIV;
        S_DIV:   state <= S_SUM;
        S_SUM:   state <= S_Q7;
        S_Q7:    state <= S_DONE;
        S_DONE:  if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sec <= pop_item.seconds;
        min <= pop_item.minutes;
        hr  <= pop_item.hours;
        day <= pop_item.day_of_month;
        mon <= pop_item.month;
        yr  <= pop_item.year;
      end
      S_MOD: q25 <= prod25[22:16];
      S_REM: rem25 <= rem25_w[4:0];
      S_WALK: begin
        // one month per beat of the walk
        if (day > 10'(len)) begin
          day <= day - 10'(len);
          if (mon == 4'd11) begin
            mon   <= 4'd0;
            yr    <= yr + 11'd1;
            rem25 <= (rem25 == 5'd24) ? 5'd0 : rem25 + 5'd1;
          end else begin
            mon <= mon + 4'd1;
          end
        end
      end
      S_DOY: begin
        yd     <= CumDays[mon] + 9'(day) - 9'd1 + 9'((mon > 4'd1) && leap);
        ys     <= full_yr - 12'(mon < 4'd2);
        sakday <= 6'(SakTab[mon]) + 6'(day);
      end
      S_DIV: begin
        q100 <= prod_a[21:16];
        q400 <= prod_b[19:16];
      end
      S_SUM: sum <= 13'(ys) + 13'(ys[11:2]) - 13'(q100) + 13'(q400) + 13'(sakday);
      S_Q7:  q7 <= prod7[26:16];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.seconds      <= sec;
      result.minutes      <= min;
      result.hours        <= hr;
      result.day_of_month <= day[4:0];
      result.month        <= mon;
      result.year         <= yr[9:0];
      result.day_of_year  <= yd;
      result.day_of_week  <= wd_w[2:0];
    end
  end

  a_walk_month: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> mon < 4'd12)
    else $error("month out of range during walk");

  a_walk_day: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> day != 10'd0)
    else $error("day reached zero during walk");

  a_rem25: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> rem25 < 5'd25)
    else $error("year residue mod 25 out of range");

  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done state");

  a_weekday: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result.day_of_week < 3'd7 && result.day_of_month != 5'd0)
    else $error("result weekday or day out of range");

endmodule
